// File: rtl/bec_pkg.sv
// Shared types and constants of the block extent coalescer.
`timescale 1ns / 1ps
package bec_pkg;

  // Layout codes held in the layout_type register.
  localparam logic [2:0] LAYOUT_SCSI        = 3'd0;
  localparam logic [2:0] LAYOUT_FBA         = 3'd1;
  localparam logic [2:0] LAYOUT_DIAG        = 3'd2;
  localparam logic [2:0] LAYOUT_ECKD        = 3'd3;
  localparam logic [2:0] LAYOUT_ECKD_COMPAT = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LAYOUT      = 2'd0;
  localparam logic [1:0] CFG_HEADS       = 2'd1;
  localparam logic [1:0] CFG_SECTORS     = 2'd2;
  localparam logic [1:0] CFG_BLOCK_SIZE  = 2'd3;

  // Limits on the extra-block count of one extent.
  localparam logic [15:0] LIMIT_SCSI  = 16'hFFFF;
  localparam logic [15:0] LIMIT_OTHER = 16'd255;

  // Width of the packed result item on the master side.
  localparam int OUT_TDATA_W = 136;

  // Status of the serial CHS divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Result of the serial CHS divider.
  typedef struct packed {
    logic [31:0] cyl;
    logic [15:0] head;
    logic [15:0] rem;
  } div_res_t;

endpackage

// File: rtl/bec_chs_div.sv
// Bit-serial chained divider that splits a block number into cylinder, head and sector.
`timescale 1ns / 1ps
module bec_chs_div #(
  parameter int BW = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [BW-1:0]      dividend,
  input  logic [15:0]        spt,
  input  logic [15:0]        hpc,
  output bec_pkg::div_stat_t stat,
  output bec_pkg::div_res_t  res
);
  import bec_pkg::*;

  localparam int CW = $clog2(BW + 1);

  logic [BW-1:0] dvd;
  logic [BW-1:0] quo;
  logic [15:0]   rem1;
  logic [15:0]   rem2;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;

  logic [16:0] t1;
  logic [16:0] t2;
  logic        ge1;
  logic        ge2;
  logic [15:0] rem1_next;
  logic [15:0] rem2_next;

  // The first stage divides by sectors per track. Each quotient bit it yields
  // is the next dividend bit of the second stage, which divides by heads.
  always_comb begin
    t1        = {rem1, dvd[BW-1]};
    ge1       = (t1 >= {1'b0, spt});
    rem1_next = ge1 ? 16'(t1 - {1'b0, spt}) : t1[15:0];
    t2        = {rem2, ge1};
    ge2       = (t2 >= {1'b0, hpc});
    rem2_next = ge2 ? 16'(t2 - {1'b0, hpc}) : t2[15:0];
  end

  // One dividend bit per cycle, most significant first.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(BW);
        dvd  <= dividend;
        rem1 <= '0;
        rem2 <= '0;
      end else if (busy) begin
        dvd  <= dvd << 1;
        quo  <= {quo[BW-2:0], ge2};
        rem1 <= rem1_next;
        rem2 <= rem2_next;
        cnt  <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign res.cyl   = 32'(quo);
  assign res.head  = rem2;
  assign res.rem   = rem1;

endmodule

// File: rtl/block_extent_coalescer_unit.sv
// Top level: maps block numbers to block pointers and merges them into extents.
//
//  channel   direction  handshake                    payload
//  s_*       in         s_tvalid / s_tready          s_tdata = block_number, s_tlast = last_block
//  m_*       out        m_tvalid / m_tready          m_tdata = extent fields, m_tlast = final_extent
//  cfg_*     in         cfg_we (no wait)             cfg_index, cfg_data
//
// A linear-layout item or a CHS hole passes through the decide, close and flush steps:
// s_tready drops at acceptance and rises again when the block returns to idle.
// A CHS item first waits in the divide step for the bit-serial divider, which works
// through the block number (at most 32 bits) and produces one quotient bit a cycle.
// rst is synchronous and clears the configuration to its defaults and drops
// any pending extent. A stall on m_tready holds the block in its emit steps
// only; the last result of an item may still wait in the output register
// while the next item is accepted.
`timescale 1ns / 1ps
module block_extent_coalescer_unit #(
  parameter int BLOCK_NUMBER_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  // block_number [31:0]
  input  logic [31:0]  s_tdata,
  input  logic         s_tlast,
  input  logic         s_tvalid,
  output logic         s_tready,
  // start_block [31:0], cylinder [63:32], track_head [79:64], sector [95:80],
  // extent_size [112:96], extra_blocks [128:113], zero fill [135:129]
  output logic [bec_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic         m_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [16:0]  cfg_data
);
  import bec_pkg::*;

  localparam int BW = (BLOCK_NUMBER_BITS < 32) ? BLOCK_NUMBER_BITS : 32;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DIV    = 5'b00010,
    S_DECIDE = 5'b00100,
    S_CLOSE  = 5'b01000,
    S_FLUSH  = 5'b10000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [2:0]  layout_type;
  logic [15:0] heads_per_cylinder;
  logic [15:0] sectors_per_track;
  logic [16:0] block_size;

  // Current item and its block pointer.
  logic [BW-1:0] b;
  logic          last;
  logic [31:0]   n_start;
  logic [31:0]   n_cyl;
  logic [15:0]   n_head;
  logic [15:0]   n_sec;

  // Pending extent.
  logic        pending_valid;
  logic [31:0] pending_start;
  logic [31:0] pending_cylinder;
  logic [15:0] pending_head;
  logic [15:0] pending_sector;
  logic [15:0] pending_count;

  // Extent closed by the current item, waiting for the output register.
  logic [31:0] closed_start;
  logic [31:0] closed_cyl;
  logic [15:0] closed_head;
  logic [15:0] closed_sec;
  logic [15:0] closed_count;
  logic        have_closed;
  logic        flush;

  logic [BW-1:0] b_in;
  logic          in_chs;
  logic          is_chs;
  logic [15:0]   spt_eff;
  logic [15:0]   hpc_eff;
  logic          div_start;
  div_stat_t     dstat;
  div_res_t      dres;
  logic          out_free;
  logic          load_out;
  logic          below_limit;
  logic          merge;
  logic [32:0]   lin_next;
  logic [16:0]   sec_next;
  logic          pend_zero;

  assign b_in     = s_tdata[BW-1:0];
  assign is_chs   = (layout_type == LAYOUT_ECKD) || (layout_type == LAYOUT_ECKD_COMPAT);
  assign in_chs   = is_chs && (b_in != '0);
  assign spt_eff  = (sectors_per_track == '0) ? 16'd1 : sectors_per_track;
  assign hpc_eff  = (heads_per_cylinder == '0) ? 16'd1 : heads_per_cylinder;
  assign s_tready = (state == S_IDLE);
  assign div_start = s_tvalid && s_tready && in_chs;
  assign out_free = !m_tvalid || m_tready;
  assign load_out = out_free && (((state == S_CLOSE) && have_closed) ||
                                 ((state == S_FLUSH) && flush));

  bec_chs_div #(
    .BW (BW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (b_in),
    .spt      (spt_eff),
    .hpc      (hpc_eff),
    .stat     (dstat),
    .res      (dres)
  );

  // Merge test against the pending extent.
  always_comb begin
    lin_next    = 33'(pending_start) + 33'(pending_count) + 33'd1;
    sec_next    = 17'(pending_sector) + 17'(pending_count) + 17'd1;
    pend_zero   = (pending_cylinder == '0) && (pending_head == '0) && (pending_sector == '0);
    below_limit = (layout_type == LAYOUT_SCSI) ? (pending_count != LIMIT_SCSI)
                                               : (pending_count < LIMIT_OTHER);
    merge = 1'b0;
    if (pending_valid && below_limit) begin
      if ((layout_type == LAYOUT_SCSI) || (layout_type == LAYOUT_FBA)) begin
        merge = (pending_start != '0) && (b != '0) && (lin_next == 33'(b));
      end else if (is_chs) begin
        merge = !pend_zero && (b != '0) && (pending_cylinder == n_cyl) &&
                (pending_head == n_head) && (sec_next == 17'(n_sec));
      end
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      layout_type        <= LAYOUT_SCSI;
      heads_per_cylinder <= 16'd15;
      sectors_per_track  <= 16'd12;
      block_size         <= 17'd4096;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LAYOUT:     layout_type        <= cfg_data[2:0];
        CFG_HEADS:      heads_per_cylinder <= cfg_data[15:0];
        CFG_SECTORS:    sectors_per_track  <= cfg_data[15:0];
        CFG_BLOCK_SIZE: block_size         <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Output valid: set when an extent is loaded, cleared once it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Item sequencer, pending extent and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      pending_valid    <= 1'b0;
      pending_start    <= '0;
      pending_cylinder <= '0;
      pending_head     <= '0;
      pending_sector   <= '0;
      pending_count    <= '0;
      have_closed      <= 1'b0;
      flush            <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            b       <= b_in;
            last    <= s_tlast;
            n_start <= is_chs ? 32'd0 : 32'(b_in);
            n_cyl   <= '0;
            n_head  <= '0;
            n_sec   <= '0;
            state   <= in_chs ? S_DIV : S_DECIDE;
          end
        end
        S_DIV: begin
          if (dstat.done) begin
            n_cyl  <= dres.cyl;
            n_head <= dres.head;
            n_sec  <= dres.rem + 16'd1;
            state  <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          closed_start <= pending_start;
          closed_cyl   <= pending_cylinder;
          closed_head  <= pending_head;
          closed_sec   <= pending_sector;
          closed_count <= pending_count;
          have_closed  <= pending_valid && !merge;
          flush        <= last;
          if (merge) begin
            pending_count <= pending_count + 16'd1;
          end else begin
            pending_valid    <= 1'b1;
            pending_start    <= n_start;
            pending_cylinder <= n_cyl;
            pending_head     <= n_head;
            pending_sector   <= n_sec;
            pending_count    <= '0;
          end
          state <= S_CLOSE;
        end
        S_CLOSE: begin
          if (!have_closed) begin
            state <= S_FLUSH;
          end else if (out_free) begin
            m_tlast  <= 1'b0;
            m_tdata  <= {7'd0, closed_count, block_size, closed_sec, closed_head,
                         closed_cyl, closed_start};
            state    <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (!flush) begin
            state <= S_IDLE;
          end else if (out_free) begin
            m_tlast          <= 1'b1;
            m_tdata          <= {7'd0, pending_count, block_size, pending_sector,
                                 pending_head, pending_cylinder, pending_start};
            pending_valid    <= 1'b0;
            pending_start    <= '0;
            pending_cylinder <= '0;
            pending_head     <= '0;
            pending_sector   <= '0;
            pending_count    <= '0;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The divider runs only while the sequencer waits for it.
  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    dstat.busy |-> (state == S_DIV))
    else $error("divider busy outside the divide step");

  // A new item is never taken while the divider still works.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !dstat.busy)
    else $error("item accepted while divider busy");

  // A flushed extent leaves nothing pending.
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH && flush && out_free) |=> !pending_valid)
    else $error("pending extent survived a flush");

  // The decision step always hands over to emission.
  a_decide_to_close: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE) |=> (state == S_CLOSE))
    else $error("decision step did not advance to emission");

endmodule

// File: sim/tb_block_extent_coalescer_unit.sv
// Self-checking testbench for the block extent coalescer: directed table, limit runs, random lists.
`timescale 1ns / 1ps
module tb_block_extent_coalescer_unit;
  import bec_pkg::*;

  // Run limits and pacing.
  localparam longint CYCLE_LIMIT   = 3_000_000;
  localparam int     SETTLE_CYCLES = 80;
  localparam int     HOLD_CYCLES   = 300;
  localparam int     SEGMENTS      = 8;
  localparam int     SEGMENT_ITEMS = 10;
  localparam int     BY_MODEL      = -1;
  localparam int     MAX_PRINTED   = 100;

  // Layout code beyond the defined ones; the block treats it like diag.
  localparam logic [2:0] LAYOUT_RESERVED = 3'd7;
  localparam logic [2:0] LAYOUT_ORDER [5] = '{LAYOUT_SCSI, LAYOUT_FBA, LAYOUT_ECKD,
                                              LAYOUT_ECKD_COMPAT, LAYOUT_DIAG};

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum logic [0:0] {ROW_ITEM, ROW_REG} row_kind_t;

  // One emitted extent, in the order of the output fields.
  typedef struct packed {
    logic [31:0] start_block;
    logic [31:0] cylinder;
    logic [15:0] track_head;
    logic [15:0] sector;
    logic [16:0] extent_size;
    logic [15:0] extra_blocks;
    logic        final_extent;
  } extent_t;

  // One row of the directed script: an item or a register write.
  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] value;
    logic [1:0]  index;
    logic        last;
    int          n_typed;
    extent_t     e0;
    extent_t     e1;
  } script_row_t;

  localparam extent_t NO_EXT = '0;

  // Directed script. Rows with n_typed of BY_MODEL are checked against the predictor.
  localparam int SCRIPT_ROWS = 34;
  localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
    // Default scsi layout: merge, hole closes, hole never merges.
    '{ROW_ITEM, 32'd100, CFG_LAYOUT, 1'b0, 0, NO_EXT, NO_EXT},
    '{ROW_ITEM, 32'd101, CFG_LAYOUT, 1'b0, 0, NO_EXT, NO_EXT},
    '{ROW_ITEM, 32'd0, CFG_LAYOUT, 1'b0, 1,
      '{32'd100, 32'd0, 16'd0, 16'd0, 17'd4096, 16'd1, 1'b0}, NO_EXT},
    '{ROW_ITEM, 32'd1, CFG_LAYOUT, 1'b1, 2,
      '{32'd0, 32'd0, 16'd0, 16'd0, 17'd4096, 16'd0, 1'b0},
      '{32'd1, 32'd0, 16'd0, 16'd0, 17'd4096, 16'd0, 1'b1}},
    // Largest block number twice: no merge.
    '{ROW_ITEM, 32'hFFFF_FFFF, CFG_LAYOUT, 1'b0, 0, NO_EXT, NO_EXT},
    '{ROW_ITEM, 32'hFFFF_FFFF, CFG_LAYOUT, 1'b1, 2,
      '{32'hFFFF_FFFF, 32'd0, 16'd0, 16'd0, 17'd4096, 16'd0, 1'b0},
      '{32'hFFFF_FFFF, 32'd0, 16'd0, 16'd0, 17'd4096, 16'd0, 1'b1}},
    // Fba with the smallest block size, merge across the top bit.
    '{ROW_REG, 32'(LAYOUT_FBA), CFG_LAYOUT, 1'b0, BY_MODEL, NO_EXT, NO_EXT},
    '{ROW_REG, 32'd512, CFG_BLOCK_SIZE, 1'b0, BY_MODEL, NO_EXT, NO_EXT},
    '{ROW_ITEM, 32'h7FFF_FFFF, CFG_LAYOUT, 1'b0, 0, NO_EXT, NO_EXT},
    '{ROW_ITEM, 32'h8000_0000, CFG_LAYOUT, 1'b1, 1,
      '{32'h7FFF_FFFF, 32'd0, 16'd0, 16'd0, 17'd512, 16'd1, 1'b1}, NO_EXT},
    // Diag never merges.
    '{ROW_REG, 32'(LAYOUT_DIAG), CFG_LAYOUT, 1'b0, BY_MODEL, NO_EXT, NO_EXT},
    '{ROW_ITEM, 32'd5, CFG_LAYOUT, 1'b0, 0, NO_EXT, NO_EXT},
    '{ROW_ITEM, 32'd6, CFG_LAYOUT, 1'b1, 2,
      '{32'd5, 32'd0, 16'd0, 16'd0, 17'd512, 16'd0, 1'b0},
      '{32'd6, 32'd0, 16'd0, 16'd0, 17'd512, 16'd0, 1'b1}},
    // Classic CHS with default geometry: hole, head change, merge, new cylinder.
    '{ROW_REG, 32'(LAYOUT_ECKD), CFG_LAYOUT, 1'b0, BY_MODEL, NO_EXT, NO_EXT},
    '{ROW_ITEM, 32'd0, CFG_LAYOUT, 1'b0, BY_MODEL, NO_EXT, NO_EXT},
    '{ROW_ITEM, 32'd13, CFG_LAYOUT, 1'b0, BY_MODEL, NO_EXT, NO_EXT},
    '{ROW_ITEM, 32'd14, CFG_LAYOUT, 1'b0, BY_MODEL, NO_EXT, NO_EXT},
    '{ROW_ITEM, 32'd900, CFG_LAYOUT, 1'b1, BY_MODEL, NO_EXT, NO_EXT},
    // Unknown layout code behaves like diag.
    '{ROW_REG, 32'(LAYOUT_RESERVED), CFG_LAYOUT, 1'b0, BY_MODEL, NO_EXT, NO_EXT},
    '{ROW_ITEM, 32'd10, CFG_LAYOUT, 1'b0, BY_MODEL, NO_EXT, NO_EXT},
    '{ROW_ITEM, 32'd11, CFG_LAYOUT, 1'b1, BY_MODEL, NO_EXT, NO_EXT},
    // Compatible CHS with zero geometry, taken as one.
    '{ROW_REG, 32'(LAYOUT_ECKD_COMPAT), CFG_LAYOUT, 1'b0, BY_MODEL, NO_EXT, NO_EXT},
    '{ROW_REG, 32'd0, CFG_HEADS, 1'b0, BY_MODEL, NO_EXT, NO_EXT},
    '{ROW_REG, 32'd0, CFG_SECTORS, 1'b0, BY_MODEL, NO_EXT, NO_EXT},
    '{ROW_ITEM, 32'd7, CFG_LAYOUT, 1'b0, BY_MODEL, NO_EXT, NO_EXT},
    '{ROW_ITEM, 32'd8, CFG_LAYOUT, 1'b1, BY_MODEL, NO_EXT, NO_EXT},
    // Largest geometry and block size with the largest block number.
    '{ROW_REG, 32'd65536, CFG_BLOCK_SIZE, 1'b0, BY_MODEL, NO_EXT, NO_EXT},
    '{ROW_REG, 32'd65535, CFG_HEADS, 1'b0, BY_MODEL, NO_EXT, NO_EXT},
    '{ROW_REG, 32'd65535, CFG_SECTORS, 1'b0, BY_MODEL, NO_EXT, NO_EXT},
    '{ROW_REG, 32'(LAYOUT_ECKD), CFG_LAYOUT, 1'b0, BY_MODEL, NO_EXT, NO_EXT},
    '{ROW_ITEM, 32'hFFFF_FFFF, CFG_LAYOUT, 1'b1, BY_MODEL, NO_EXT, NO_EXT},
    // Layout switched while a CHS extent is still open.
    '{ROW_ITEM, 32'd50, CFG_LAYOUT, 1'b0, BY_MODEL, NO_EXT, NO_EXT},
    '{ROW_REG, 32'(LAYOUT_SCSI), CFG_LAYOUT, 1'b0, BY_MODEL, NO_EXT, NO_EXT},
    '{ROW_ITEM, 32'd1, CFG_LAYOUT, 1'b1, BY_MODEL, NO_EXT, NO_EXT}
  };

  // Clock, reset and block ports; every input starts at a known value.
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [31:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic m_tlast;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;

  // Shadow configuration and the open extent as the block should hold them.
  logic [2:0]  cfg_layout = LAYOUT_SCSI;
  logic [15:0] cfg_heads = 16'd15;
  logic [15:0] cfg_sectors = 16'd12;
  logic [16:0] cfg_block_size = 17'd4096;
  bit          open_valid = 1'b0;
  logic [63:0] open_start = '0;
  logic [63:0] open_cyl = '0;
  logic [63:0] open_head = '0;
  logic [63:0] open_sector = '0;
  int unsigned open_extra = 0;

  extent_t expected_extents [$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  logic hold_req = 1'b0;
  int unsigned hold_left = 0;
  logic [31:0] prev_block = '0;
  longint cycle_count = 0;
  longint items_sent = 0;
  longint extents_checked = 0;
  int mismatch_count = 0;

  block_extent_coalescer_unit DUT (
    .clk(clk),
    .rst(rst),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d extents outstanding.",
               cycle_count, expected_extents.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long counted hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    m_tready <= !hold_req && hold_left == 0 && $urandom_range(0, 99) >= stall_pct;
  end

  // Count a mismatch and print it while the log stays short.
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("MISMATCH: %s", msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("extent %0d %s got %0h expected %0h",
                                extents_checked, name, got, want));
  endtask

  // Compare one accepted extent with the oldest expectation.
  task automatic check_extent(input logic [OUT_TDATA_W-1:0] data, input logic tlast);
    extent_t want;
    extents_checked++;
    if (expected_extents.size() == 0) begin
      report_mismatch($sformatf("extent %0d (start %0h) arrived with none expected",
                                extents_checked, data[31:0]));
      return;
    end
    want = expected_extents.pop_front();
    compare_field("start_block", data[31:0], want.start_block);
    compare_field("cylinder", data[63:32], want.cylinder);
    compare_field("track_head", 32'(data[79:64]), 32'(want.track_head));
    compare_field("sector", 32'(data[95:80]), 32'(want.sector));
    compare_field("extent_size", 32'(data[112:96]), 32'(want.extent_size));
    compare_field("extra_blocks", 32'(data[128:113]), 32'(want.extra_blocks));
    compare_field("zero fill", 32'(data[135:129]), 32'd0);
    compare_field("final_extent", 32'(tlast), 32'(want.final_extent));
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_extent(m_tdata, m_tlast);
  end

  // The open extent as it would be emitted now.
  function automatic extent_t open_extent(input logic is_final);
    extent_t e;
    e.start_block  = open_start[31:0];
    e.cylinder     = open_cyl[31:0];
    e.track_head   = open_head[15:0];
    e.sector       = open_sector[15:0];
    e.extent_size  = cfg_block_size;
    e.extra_blocks = open_extra[15:0];
    e.final_extent = is_final;
    return e;
  endfunction

  // Map one block number to a pointer, merge or close, and flush on the last one.
  task automatic predict_extents(input logic [31:0] bn, input logic last,
                                 output extent_t r0, output extent_t r1, output int n);
    logic [63:0] b, h, s, n_start, n_cyl, n_head, n_sec;
    int unsigned limit;
    bit chs, linear_merge, merges;
    b = {32'd0, bn};
    h = (cfg_heads == '0) ? 64'd1 : {48'd0, cfg_heads};
    s = (cfg_sectors == '0) ? 64'd1 : {48'd0, cfg_sectors};
    n_start = '0;
    n_cyl = '0;
    n_head = '0;
    n_sec = '0;
    r0 = '0;
    r1 = '0;
    n = 0;
    merges = 1'b0;
    chs = cfg_layout == LAYOUT_ECKD || cfg_layout == LAYOUT_ECKD_COMPAT;
    linear_merge = cfg_layout == LAYOUT_SCSI || cfg_layout == LAYOUT_FBA;
    limit = (cfg_layout == LAYOUT_SCSI) ? 32'(LIMIT_SCSI) : 32'(LIMIT_OTHER);

    if (chs) begin
      if (b != 0) begin
        n_cyl = b / (h * s);
        n_head = (b / s) % h;
        n_sec = b % s + 1;
      end
    end else begin
      n_start = b;
    end

    // Merge only into a non-hole extent, directly after it, within the count limit.
    if (open_valid && open_extra + 1 <= limit) begin
      if (linear_merge) begin
        merges = open_start != 0 && b != 0 && open_start + open_extra + 1 == b;
      end else if (chs) begin
        merges = !(open_cyl == 0 && open_head == 0 && open_sector == 0) && b != 0 &&
                 open_cyl == n_cyl && open_head == n_head &&
                 open_sector + open_extra + 1 == n_sec;
      end
    end

    if (merges) begin
      open_extra++;
    end else begin
      if (open_valid) begin
        r0 = open_extent(1'b0);
        n = 1;
      end
      open_valid = 1'b1;
      open_start = n_start;
      open_cyl = n_cyl;
      open_head = n_head;
      open_sector = n_sec;
      open_extra = 0;
    end

    if (last) begin
      if (n == 0) r0 = open_extent(1'b1);
      else r1 = open_extent(1'b1);
      n++;
      open_valid = 1'b0;
      open_start = '0;
      open_cyl = '0;
      open_head = '0;
      open_sector = '0;
      open_extra = 0;
    end
  endtask

  // Offer one item, wait for it to be taken, then record what it should produce.
  task automatic send_item(input logic [31:0] bn, input logic last,
                           input int n_typed = BY_MODEL,
                           input extent_t t0 = '0, input extent_t t1 = '0);
    extent_t r0, r1;
    int n;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata <= bn;
    s_tlast <= last;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_extents(bn, last, r0, r1, n);
    if (n_typed != BY_MODEL) begin
      n = n_typed;
      r0 = t0;
      r1 = t1;
    end
    if (n > 0) expected_extents.push_back(r0);
    if (n > 1) expected_extents.push_back(r1);
    items_sent++;
  endtask

  // Stop sending, collect every expected extent, and let a result-less item finish.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_extents.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write, mirrored into the shadow configuration.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[16:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_LAYOUT:     cfg_layout = value[2:0];
      CFG_HEADS:      cfg_heads = value[15:0];
      CFG_SECTORS:    cfg_sectors = value[15:0];
      CFG_BLOCK_SIZE: cfg_block_size = value[16:0];
      default: ;
    endcase
  endtask

  task automatic set_idle_mode(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 70; stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 70; end
      default:       begin send_idle_pct = 31; stall_pct = 31; end
    endcase
  endtask

  // Mostly contiguous blocks, with holes, jumps and near misses mixed in.
  task automatic next_block(output logic [31:0] bn);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) bn = prev_block + 1;
    else if (pick < 65) bn = '0;
    else if (pick < 80) bn = $urandom;
    else if (pick < 92) bn = $urandom_range(1, 4000);
    else bn = prev_block + 2;
    prev_block = bn;
  endtask

  function automatic logic [31:0] pick_geometry();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'd65535;
      3, 4: return $urandom_range(2, 20);
      default: return $urandom_range(0, 17'h1FFFF);
    endcase
  endfunction

  function automatic logic [31:0] pick_block_size();
    case ($urandom_range(0, 3))
      0: return 32'd512;
      1: return 32'd65536;
      2: return 32'd4096;
      default: return $urandom_range(512, 65536);
    endcase
  endfunction

  initial begin
    logic [31:0] bn;
    int list_left;
    list_left = 0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed script under the reset configuration first.
    set_idle_mode(IDLE_NONE);
    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].kind == ROW_REG) begin
        drain();
        write_reg(SCRIPT[i].index, SCRIPT[i].value);
      end else begin
        send_item(SCRIPT[i].value, SCRIPT[i].last, SCRIPT[i].n_typed,
                  SCRIPT[i].e0, SCRIPT[i].e1);
      end
    end

    // Extra-block count limit: a long contiguous fba run splits after 255 extra blocks.
    drain();
    write_reg(CFG_LAYOUT, 32'(LAYOUT_FBA));
    for (int k = 0; k <= 256; k++) send_item(32'd1000 + k, k == 256);

    // Long receiver hold-off while diag items keep coming, so the block backs up.
    drain();
    write_reg(CFG_LAYOUT, 32'(LAYOUT_DIAG));
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    for (int k = 0; k < 40; k++) begin
      next_block(bn);
      send_item(bn, k == 39);
    end

    // Random lists; each segment gets a fresh configuration and pacing.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain();
      set_idle_mode(idle_mode_t'(seg % 4));
      write_reg(CFG_LAYOUT, (seg < 5) ? 32'(LAYOUT_ORDER[seg]) : $urandom_range(0, 7));
      write_reg(CFG_HEADS, pick_geometry());
      write_reg(CFG_SECTORS, pick_geometry());
      write_reg(CFG_BLOCK_SIZE, pick_block_size());
      for (int k = 0; k < SEGMENT_ITEMS; k++) begin
        if (list_left == 0) list_left = $urandom_range(1, 16);
        list_left--;
        next_block(bn);
        send_item(bn, list_left == 0);
      end
    end

    drain();
    $display("Sent %0d block numbers: directed cases, a count limit, a long output stall",
             items_sent);
    $display("and random lists over every layout code; %0d extents compared.",
             extents_checked);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches.", mismatch_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/bec_pkg.sv
rtl/bec_chs_div.sv
rtl/block_extent_coalescer_unit.sv
sim/tb_block_extent_coalescer_unit.sv
